// ===== rtl/mra_pkg.sv =====
// Shared constants, codes and types of the mutual exclusion request arbiter.
package mra_pkg;

    // Defaults for the top-level parameters
    localparam int LOCK_COUNT_DEF = 128;
    localparam int NODE_COUNT_DEF = 16;
    localparam int SEQ_BITS_DEF   = 16;

    // Fixed field widths
    localparam int LOCK_ID_W    = 7;
    localparam int NODE_W       = 4;
    localparam int NODE_TOTAL_W = 5;
    localparam int SEQ_W        = 16;
    localparam int KIND_W       = 3;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 1;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Message opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEFERRED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL = 1'b1;

    // Configuration reset values
    localparam logic [NODE_W-1:0]       NODE_ID_RST    = 4'd0;
    localparam logic [NODE_TOTAL_W-1:0] NODE_TOTAL_RST = 5'd16;

    // Control from the sequencer to the deferred-reply scanner
    typedef struct packed {
        logic load;
        logic step;
    } scan_ctl_t;

endpackage

// ===== rtl/mra_scan.sv =====
// Deferred-reply scanner: walks a node mask lowest bit first, one node per step.
module mra_scan #(
    parameter int NODE_COUNT = mra_pkg::NODE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mra_pkg::scan_ctl_t            ctl,
    input  logic [NODE_COUNT-1:0]         load_mask,
    output logic                          pending,
    output logic [$clog2(NODE_COUNT)-1:0] idx
);
    import mra_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [NODE_COUNT-1:0] mask_reg;
    logic [NODE_COUNT-1:0] mask_next;

    // Load a fresh mask or drop the lowest set bit
    always_comb
    begin
        mask_next = mask_reg;
        if (ctl.load)
        begin
            mask_next = load_mask;
        end
        else if (ctl.step)
        begin
            mask_next = mask_reg & (mask_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // Lowest set bit wins
    always_comb
    begin
        idx = '0;
        for (int j = NODE_COUNT - 1; j >= 0; j--)
        begin
            if (mask_reg[j])
            begin
                idx = IDX_W'(j);
            end
        end
    end

    assign pending = |mask_reg;

endmodule

// ===== rtl/mutual_exclusion_request_arbiter.sv =====
// Top level of the per-lock Ricart-Agrawala request arbiter.
//
//  Channel   Dir  Handshake          Contents
//  s_*       in   s_tvalid/s_tready  message word: op, lock, sender, sequence number
//  m_*       out  m_tvalid/m_tready  result word: kind, sequence, destination, last
//  cfg_*     in   cfg_we             node_id and node count register writes
//
//  Lock state sits in one LOCK_COUNT-deep memory with a registered read.
//  A request or remote message is a memory read, then a modify and write back.
//  A release reads and writes back the lock, then sends one word per deferred node and a done word.
//  After reset a clearing pass over all LOCK_COUNT entries marks every lock unused;
//  no word is taken meanwhile. A stalled output holds the sequencer while it has a word to push.
module mutual_exclusion_request_arbiter #(
    parameter int LOCK_COUNT = mra_pkg::LOCK_COUNT_DEF,
    parameter int NODE_COUNT = mra_pkg::NODE_COUNT_DEF,
    parameter int SEQ_BITS   = mra_pkg::SEQ_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration
    input  logic                            cfg_we,
    input  logic [mra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mra_pkg::CFG_W-1:0]       cfg_data,
    // Message stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mra_pkg::S_TDATA_W-1:0]   s_tdata,   // lock_id[6:0], sender[10:7], seq_num[26:11]
    input  logic                            s_tuser,   // op
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mra_pkg::M_TDATA_W-1:0]   m_tdata,   // seq_out[15:0], dest_node[19:16]
    output logic [mra_pkg::KIND_W-1:0]      m_tuser,   // kind
    output logic                            m_tlast    // last
);
    import mra_pkg::*;

    localparam int LIDX_W    = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int LOCK_SPAN = 2 ** LOCK_ID_W;
    localparam int NIDX_W    = $clog2(NODE_COUNT);
    localparam logic [SEQ_BITS-1:0] SEQ_MAX   = {SEQ_BITS{1'b1}};
    localparam logic [LIDX_W-1:0]   LAST_LOCK = LIDX_W'(LOCK_COUNT - 1);

    // Sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic                  req;
        logic [SEQ_BITS-1:0]   own;
        logic [SEQ_BITS-1:0]   high;
        logic [NODE_COUNT-1:0] defer;
    } entry_t;

    // Lock memory
    entry_t mem [LOCK_COUNT];
    entry_t entry_rd_reg;
    logic   mem_we;
    logic [LIDX_W-1:0] mem_waddr;
    entry_t mem_wdata;

    logic [1:0]        state_reg, state_next;
    logic [LIDX_W-1:0] clr_addr_reg, clr_addr_next;

    logic [NODE_W-1:0]       node_id_reg;
    logic [NODE_TOTAL_W-1:0] node_total_reg;

    // Latched message
    logic                op_reg;
    logic [LIDX_W-1:0]   lidx_reg;
    logic [NODE_W-1:0]   sender_reg;
    logic [SEQ_BITS-1:0] seq_reg;

    // Output register
    logic                out_valid_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [NODE_W-1:0]   out_dest_reg;
    logic                out_last_reg;

    logic              push;
    logic [KIND_W-1:0] push_kind;
    logic [SEQ_W-1:0]  push_seq;
    logic [NODE_W-1:0] push_dest;
    logic              push_last;
    logic              can_push;
    logic              in_acc;

    logic [LOCK_ID_W-1:0] in_lock;
    logic [NODE_W-1:0]    in_sender;
    logic [SEQ_W-1:0]     in_seq;
    logic [LIDX_W-1:0]    lk_tab [LOCK_SPAN];

    logic [SEQ_BITS-1:0]   cur_own, cur_high, grant, new_high;
    logic                  cur_req;
    logic [NODE_COUNT-1:0] cur_defer, lim_mask, sender_1h;
    logic                  bad, is_local, defer_hit, exec_release;

    scan_ctl_t         scan_ctl;
    logic              scan_pending;
    logic [NIDX_W-1:0] scan_idx;

    // Input unpacking
    assign in_lock   = s_tdata[LOCK_ID_W-1:0];
    assign in_sender = s_tdata[LOCK_ID_W+NODE_W-1:LOCK_ID_W];
    assign in_seq    = s_tdata[LOCK_ID_W+NODE_W+SEQ_W-1:LOCK_ID_W+NODE_W];

    // Lock number folded into the memory depth
    for (genvar g = 0; g < LOCK_SPAN; g++)
    begin : g_lk_tab
        assign lk_tab[g] = LIDX_W'(g % LOCK_COUNT);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign can_push = !out_valid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= NODE_ID_RST;
            node_total_reg <= NODE_TOTAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NODE_ID:    node_id_reg    <= cfg_data[NODE_W-1:0];
                CFG_NODE_TOTAL: node_total_reg <= cfg_data[NODE_TOTAL_W-1:0];
            endcase
        end
    end

    // Message latch
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg     <= s_tuser;
            lidx_reg   <= lk_tab[in_lock];
            sender_reg <= in_sender;
            seq_reg    <= SEQ_BITS'(in_seq);
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc)
        begin
            entry_rd_reg <= mem[lk_tab[in_lock]];
        end
    end

    // Current lock view: an unused lock reads as all zero
    assign cur_req   = entry_rd_reg.valid && entry_rd_reg.req;
    assign cur_own   = entry_rd_reg.valid ? entry_rd_reg.own   : '0;
    assign cur_high  = entry_rd_reg.valid ? entry_rd_reg.high  : '0;
    assign cur_defer = entry_rd_reg.valid ? entry_rd_reg.defer : '0;

    always_comb
    begin
        for (int j = 0; j < NODE_COUNT; j++)
        begin
            lim_mask[j]  = ({27'd0, node_total_reg} > j);
            sender_1h[j] = ({28'd0, sender_reg} == j);
        end
    end

    assign bad      = ({1'b0, sender_reg} >= node_total_reg) ||
                      ({28'd0, sender_reg} >= NODE_COUNT);
    assign is_local = (sender_reg == node_id_reg);
    assign grant    = (cur_high == SEQ_MAX) ? cur_high : cur_high + 1'b1;
    assign new_high = (seq_reg > cur_high) ? seq_reg : cur_high;
    assign defer_hit = cur_req && ((seq_reg > cur_own) ||
                       ((seq_reg == cur_own) && (sender_reg > node_id_reg)));
    assign exec_release = !bad && is_local && (op_reg == OP_RELEASE);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = lidx_reg;
        mem_wdata     = entry_rd_reg;
        push          = 1'b0;
        push_kind     = KIND_ERROR;
        push_seq      = '0;
        push_dest     = '0;
        push_last     = 1'b1;
        scan_ctl      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_LOCK)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (can_push || exec_release)
                begin
                    state_next = ST_IDLE;
                    priority if (bad)
                    begin
                        push = 1'b1;
                    end
                    else if (is_local && (op_reg == OP_REQUEST))
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{valid: 1'b1, req: 1'b1, own: grant,
                                      high: cur_high, defer: cur_defer};
                        push      = 1'b1;
                        push_kind = KIND_GRANTED;
                        push_seq  = SEQ_W'(grant);
                    end
                    else if (is_local)
                    begin
                        // release: hand the deferred nodes to the scanner
                        mem_we        = 1'b1;
                        mem_wdata     = '{valid: 1'b1, req: 1'b0, own: cur_own,
                                          high: cur_high, defer: '0};
                        scan_ctl.load = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{valid: 1'b1, req: cur_req, own: cur_own, high: new_high,
                                      defer: defer_hit ? (cur_defer | sender_1h) : cur_defer};
                        push      = 1'b1;
                        push_kind = defer_hit ? KIND_DEFERRED : KIND_REPLY;
                        push_dest = defer_hit ? '0 : sender_reg;
                    end
                end
            end
            ST_SCAN:
            begin
                if (can_push)
                begin
                    push = 1'b1;
                    if (scan_pending)
                    begin
                        push_kind     = KIND_RELEASED;
                        push_dest     = NODE_W'(scan_idx);
                        push_last     = 1'b0;
                        scan_ctl.step = 1'b1;
                    end
                    else
                    begin
                        push_kind  = KIND_DONE;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    mra_scan #(
        .NODE_COUNT (NODE_COUNT)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .load_mask (cur_defer & lim_mask),
        .pending   (scan_pending),
        .idx       (scan_idx)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_kind_reg <= push_kind;
            out_seq_reg  <= push_seq;
            out_dest_reg <= push_dest;
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_dest_reg, out_seq_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // An accepted word always goes to the modify step next
    a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_EXEC))
        else $error("accepted word did not reach modify step");

    // Deferred nodes are only outstanding while a release is draining
    a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_pending |-> (state_reg == ST_SCAN))
        else $error("deferred mask left over outside release drain");

    // Only released replies are followed by more words of the same message
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_RELEASED)))
        else $error("last flag does not match result kind");

endmodule

// ===== verif/mutual_exclusion_request_arbiter_tb.sv =====
// Testbench for the mutual exclusion request arbiter: per-lock prediction, checked result stream.
`timescale 1ns / 1ps

module mutual_exclusion_request_arbiter_tb;
    import mra_pkg::*;

    // Per-lock Ricart-Agrawala predictor plus the queue of result words still owed by the block
    class lock_arbiter_scoreboard;

        typedef struct packed {
            logic [KIND_W-1:0] kind;
            logic [SEQ_W-1:0]  seq_out;
            logic [NODE_W-1:0] dest_node;
            logic              last;
        } result_word_t;

        // Register copies
        logic [NODE_W-1:0]       node_id    = NODE_ID_RST;
        logic [NODE_TOTAL_W-1:0] node_total = NODE_TOTAL_RST;

        // Lock table
        bit                        lock_used    [LOCK_COUNT_DEF];
        bit [SEQ_W-1:0]            top_seq      [LOCK_COUNT_DEF];
        bit [SEQ_W-1:0]            my_seq       [LOCK_COUNT_DEF];
        bit                        want_lock    [LOCK_COUNT_DEF];
        bit [NODE_COUNT_DEF-1:0]   waiting_mask [LOCK_COUNT_DEF];

        result_word_t expected_words[$];
        int unsigned  errors = 0;

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_NODE_ID)
                node_id = value[NODE_W-1:0];
            else
                node_total = value;
        endfunction

        function int scan_bound();
            return (node_total < NODE_COUNT_DEF) ? int'(node_total) : NODE_COUNT_DEF;
        endfunction

        function void owe(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                          logic [NODE_W-1:0] dest, logic last);
            result_word_t w;
            w.kind      = kind;
            w.seq_out   = seq;
            w.dest_node = dest;
            w.last      = last;
            expected_words.push_back(w);
        endfunction

        // Accepted message word: update the lock table and queue the words it causes
        function void note_message(logic op, logic [LOCK_ID_W-1:0] lk, logic [NODE_W-1:0] snd,
                                   logic [SEQ_W-1:0] sq);
            int               bound;
            logic [SEQ_W-1:0] grant;
            bound = scan_bound();
            if (int'(snd) >= bound)
            begin
                owe(KIND_ERROR, '0, '0, 1'b1);
                return;
            end
            // first touch of a lock wipes its entry
            if (!lock_used[lk])
            begin
                lock_used[lk]    = 1'b1;
                top_seq[lk]      = '0;
                my_seq[lk]       = '0;
                want_lock[lk]    = 1'b0;
                waiting_mask[lk] = '0;
            end
            if (snd == node_id && op == OP_REQUEST)
            begin
                grant = (top_seq[lk] == {SEQ_W{1'b1}}) ? {SEQ_W{1'b1}} : top_seq[lk] + 1'b1;
                want_lock[lk] = 1'b1;
                my_seq[lk]    = grant;
                owe(KIND_GRANTED, grant, '0, 1'b1);
            end
            else if (snd == node_id)
            begin
                want_lock[lk] = 1'b0;
                for (int j = 0; j < bound; j++)
                    if (waiting_mask[lk][j])
                        owe(KIND_RELEASED, '0, NODE_W'(j), 1'b0);
                waiting_mask[lk] = '0;
                owe(KIND_DONE, '0, '0, 1'b1);
            end
            else
            begin
                // remote message, whatever its op
                if (top_seq[lk] < sq)
                    top_seq[lk] = sq;
                if (want_lock[lk] && (sq > my_seq[lk] || (sq == my_seq[lk] && snd > node_id)))
                begin
                    waiting_mask[lk][snd] = 1'b1;
                    owe(KIND_DEFERRED, '0, '0, 1'b1);
                end
                else
                    owe(KIND_REPLY, '0, snd, 1'b1);
            end
        endfunction

        // Accepted result word against the oldest one owed
        function void check_result(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                                   logic [NODE_W-1:0] dest, logic last);
            result_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("result word with none expected: kind %0d seq %0d dest %0d last %0d",
                       kind, seq, dest, last);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (kind !== w.kind)
            begin
                $error("kind: expected %0d, actual %0d", w.kind, kind);
                errors++;
            end
            if (seq !== w.seq_out)
            begin
                $error("seq_out: expected %0d, actual %0d", w.seq_out, seq);
                errors++;
            end
            if (dest !== w.dest_node)
            begin
                $error("dest_node: expected %0d, actual %0d", w.dest_node, dest);
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last: expected %0d, actual %0d", w.last, last);
                errors++;
            end
        endfunction

    endclass

    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // lock_id[6:0], sender[10:7], seq_num[26:11]
    logic                   s_tuser;    // op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // seq_out[15:0], dest_node[19:16]
    logic [KIND_W-1:0]      m_tuser;    // kind
    logic                   m_tlast;

    lock_arbiter_scoreboard sb = new;
    bit gaps_on = 1'b1;
    int idle_cycles = 0;
    int stall_left  = 0;
    int phase_node [PHASES] = '{15, 5, 0, 3, 10, 1, 12};
    int phase_num  [PHASES] = '{16, 8, 1, 0, 31, 2, 13};

    mutual_exclusion_request_arbiter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Result side: random stall bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[SEQ_W-1:0], m_tdata[SEQ_W+NODE_W-1:SEQ_W], m_tlast);

    // Watchdog: cycles without any word moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One message word; called and returns at a falling edge
    task automatic send_message(input logic op, input logic [LOCK_ID_W-1:0] lk,
                                input logic [NODE_W-1:0] snd, input logic [SEQ_W-1:0] sq);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, sq, snd, lk};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_message(op, lk, snd, sq);
        @(negedge clk);
    endtask

    // Drain all owed words, then let the sequencer settle
    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Both registers, back to back
    task automatic write_config(input logic [CFG_W-1:0] node_val, input logic [CFG_W-1:0] num_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_ID;
        cfg_data  <= node_val;
        @(negedge clk);
        cfg_index <= CFG_NODE_TOTAL;
        cfg_data  <= num_val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_register(CFG_NODE_ID, node_val);
        sb.write_register(CFG_NODE_TOTAL, num_val);
    endtask

    // Request/release traffic concentrated on a few locks, with some noise
    task automatic random_messages(input int count);
        logic [LOCK_ID_W-1:0] pool [3];
        logic [LOCK_ID_W-1:0] lk;
        logic [NODE_W-1:0]    snd;
        logic [SEQ_W-1:0]     sq;
        logic                 op;
        int                   pick;
        int                   bound;
        for (int p = 0; p < 3; p++)
            pool[p] = LOCK_ID_W'($urandom);
        for (int i = 0; i < count; i++)
        begin
            bound = sb.scan_bound();
            lk    = ($urandom_range(0, 9) == 0) ? LOCK_ID_W'($urandom) : pool[$urandom_range(0, 2)];
            pick  = $urandom_range(0, 99);
            op    = OP_REQUEST;
            sq    = SEQ_W'($urandom);
            if (pick < 20)
                snd = sb.node_id;
            else if (pick < 35)
            begin
                snd = sb.node_id;
                op  = OP_RELEASE;
            end
            else if (pick < 85)
            begin
                snd = (bound > 0) ? NODE_W'($urandom_range(0, bound - 1)) : NODE_W'($urandom);
                op  = ($urandom_range(0, 7) == 0) ? OP_RELEASE : OP_REQUEST;
                // aim at the own number so ties and near misses occur
                if (pick < 60)
                    sq = sb.my_seq[lk];
                else if (pick < 72)
                    sq = sb.my_seq[lk] + SEQ_W'($urandom_range(0, 2)) - 1'b1;
            end
            else
            begin
                snd = NODE_W'($urandom);
                op  = 1'($urandom);
            end
            send_message(op, lk, snd, sq);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset config, node 0 of 16
        send_message(OP_RELEASE, 7'd5,   4'd0,  16'd0);        // release on an unused lock
        send_message(OP_REQUEST, 7'd0,   4'd0,  16'd0);        // grant 1
        send_message(OP_REQUEST, 7'd0,   4'd15, 16'hFFFF);     // larger number, deferred
        send_message(OP_REQUEST, 7'd0,   4'd3,  16'd1);        // tie, larger sender, deferred
        send_message(OP_REQUEST, 7'd0,   4'd2,  16'd0);        // smaller number, answered
        send_message(OP_RELEASE, 7'd0,   4'd7,  16'd5);        // remote release acts as request
        send_message(OP_REQUEST, 7'd0,   4'd0,  16'd0);        // repeated request saturates
        send_message(OP_REQUEST, 7'd0,   4'd0,  16'd0);
        send_message(OP_RELEASE, 7'd0,   4'd0,  16'd0);        // frees 3, 7, 15
        send_message(OP_REQUEST, 7'd127, 4'd1,  16'h5555);
        send_message(OP_REQUEST, 7'd127, 4'd14, 16'hAAAA);
        send_message(OP_REQUEST, 7'd127, 4'd0,  16'd0);
        send_message(OP_RELEASE, 7'd127, 4'd0,  16'd0);
        random_messages(35);

        // Further register settings, extremes included
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle(6);
            if (ph == PHASES - 1)
                gaps_on = 1'b0;
            write_config({1'($urandom), 4'(phase_node[ph])}, 5'(phase_num[ph]));
            // a random sender ties with the own number
            send_message(OP_REQUEST, 7'd9, sb.node_id, 16'd0);
            send_message(OP_REQUEST, 7'd9, NODE_W'($urandom), sb.my_seq[9]);
            random_messages(30);
        end

        wait_idle(30);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
